>>> hw/rtl/stbs_pkg.sv
// shared types, widths and codes for the sorted table search core
`default_nettype none

package stbs_pkg;

    // table geometry default
    localparam int TABLE_ENTRIES = 256;

    // field widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 16;
    localparam int WORD_W  = 64;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 8;
    localparam int ENTRY_W = KEY_W + WORD_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // request beat
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] entry_word;
    } t_req;

    // response beat
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] found_word;
        logic [POS_W-1:0]  position;
    } t_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_table_binary_search_core.sv
// Sorted key table with binary search. Clear and append beats go straight
// to the done state; a search beat makes at most floor(log2(stored
// entries)) + 1 probes. Probes are paced by the single table ram, which
// returns one record per cycle to the key comparator. Results leave
// through an output register, so a finished result may wait there while
// the next beat is taken. Entries beyond the fill count are never used by a
// search; there is no clearing pass.
`default_nettype none

module sorted_table_binary_search_core #(
    parameter int ENTRIES = stbs_pkg::TABLE_ENTRIES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_stall,
    input  wire stbs_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_stall,
    output stbs_pkg::t_rsp      o_rsp
);

    import stbs_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    logic               done;
    logic               load;
    t_rsp               result;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    // key and word table
    stbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    stbs_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_done      (done),
        .i_take      (load),
        .o_result    (result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // output register loads when empty or being drained
    assign load = done && (!r_rsp_valid || !i_rsp_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (load) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rsp <= result;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // a taken request beat keeps the input side stalled until its result moves to the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("input not stalled after accepting a beat");

    // a new response only appears after the sequencer finished
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(done))
        else $error("response without finished item");

    // miss and full results carry no word and no position
    a_nonhit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_OK)
            |-> (o_rsp.found_word == '0) && (o_rsp.position == '0))
        else $error("nonzero payload on miss or full");

    // status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.status == ST_OK) || (o_rsp.status == ST_MISS)
            || (o_rsp.status == ST_FULL))
        else $error("undefined status code");

endmodule

`default_nettype wire

>>> hw/rtl/stbs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/stbs_ctrl.sv
// sequencer: clear, append and binary search probing through the table ram
`default_nettype none

module stbs_ctrl #(
    parameter int ENTRIES = stbs_pkg::TABLE_ENTRIES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_stall,
    input  wire stbs_pkg::t_req             i_req,
    output logic                            o_done,
    input  wire logic                       i_take,
    output stbs_pkg::t_rsp                  o_result,
    output logic                            o_ram_we,
    output logic [$clog2(ENTRIES)-1:0]      o_ram_waddr,
    output logic [stbs_pkg::ENTRY_W-1:0]    o_ram_wdata,
    output logic [$clog2(ENTRIES)-1:0]      o_ram_raddr,
    input  wire logic [stbs_pkg::ENTRY_W-1:0] i_ram_rdata
);

    import stbs_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = (AW > POS_W) ? AW : POS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hiex, n_hiex;
    logic [AW-1:0]    r_mid, n_mid;
    logic [KEY_W-1:0] r_key, n_key;
    t_rsp             r_res, n_res;

    logic             accept;
    logic [CW:0]      mid_sum;
    logic [KEY_W-1:0] rd_key;
    logic [WORD_W-1:0] rd_word;

    // low bits of a table index as the position field
    function automatic logic [POS_W-1:0] to_pos(input logic [AW-1:0] idx);
        logic [PW-1:0] ext;
        ext = PW'(idx);
        return ext[POS_W-1:0];
    endfunction

    assign accept  = i_req_valid && (r_state == S_IDLE);
    assign rd_key  = i_ram_rdata[WORD_W +: KEY_W];
    assign rd_word = i_ram_rdata[WORD_W-1:0];

    // next state, bound update and probe address
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hiex      = r_hiex;
        n_key       = r_key;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = {i_req.key, i_req.entry_word};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key = i_req.key;
                    n_res = '0;
                    n_state = S_DONE;
                    unique case (i_req.op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (r_count >= CW'(ENTRIES)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_ram_we       = 1'b1;
                                n_count        = r_count + CW'(1);
                                n_res.position = to_pos(r_count[AW-1:0]);
                            end
                        end
                        OP_SEARCH: begin
                            n_lo   = '0;
                            n_hiex = r_count;
                            if (r_count == '0) begin
                                n_res.status = ST_MISS;
                            end else begin
                                n_state = S_PROBE;
                            end
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                // one compare per cycle against the key read last cycle
                if (r_key > rd_key) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else if (r_key < rd_key) begin
                    n_hiex = CW'(r_mid);
                end
                if (r_key == rd_key) begin
                    n_res.status     = ST_OK;
                    n_res.found_word = rd_word;
                    n_res.position   = to_pos(r_mid);
                    n_state          = S_DONE;
                end else if (!(n_lo < n_hiex)) begin
                    n_res.status = ST_MISS;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // midpoint of the inclusive range, rounded down
        mid_sum = {1'b0, n_lo} + {1'b0, n_hiex} - (CW+1)'(1);
        n_mid   = mid_sum[AW:1];
    end

    assign o_ram_raddr = n_mid;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hiex <= n_hiex;
        r_mid  <= n_mid;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_result    = r_res;

endmodule

`default_nettype wire

>>> sim/tb_sorted_table_binary_search_core.sv
// testbench for the sorted table search core: queue-fed driver, checking monitor, table model
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_core;
    import stbs_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int LIMIT_CYCLES = 300000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 30;
    localparam int PHASE_ITEMS  = 225;

    // the op code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic i_rsp_stall = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // stimulus and expected responses
    t_req req_backlog[$];
    t_rsp due_rsps[$];
    logic [KEY_W-1:0] session_keys[$];
    int item_total = 0;

    // table copy kept by the testbench
    logic [KEY_W-1:0]  tbl_key [TABLE_ENTRIES];
    logic [WORD_W-1:0] tbl_word[TABLE_ENTRIES];
    int tbl_count = 0;

    // flow control knobs
    int send_idle_pct = 36;
    int recv_idle_pct = 83;
    int hold_asked    = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    int err_count   = 0;
    int cycle_count = 0;

    sorted_table_binary_search_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    // clock
    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // apply one request to the table copy and return the response it gives
    function automatic t_rsp table_response(input t_req r);
        t_rsp rsp;
        int   lo;
        int   hi;
        int   mid;
        bit   hit;
        rsp = '0;
        case (r.op)
            OP_CLEAR: tbl_count = 0;
            OP_APPEND: begin
                if (tbl_count >= TABLE_ENTRIES) begin
                    rsp.status = ST_FULL;
                end else begin
                    tbl_key[tbl_count]  = r.key;
                    tbl_word[tbl_count] = r.entry_word;
                    rsp.position        = POS_W'(tbl_count);
                    tbl_count++;
                end
            end
            OP_SEARCH: begin
                // inclusive bounds, midpoint rounded down, stop when bounds cross
                rsp.status = ST_MISS;
                lo  = 0;
                hi  = tbl_count - 1;
                hit = 1'b0;
                while (!hit && lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (r.key > tbl_key[mid]) begin
                        lo = mid + 1;
                    end else if (r.key < tbl_key[mid]) begin
                        hi = mid - 1;
                    end else begin
                        hit            = 1'b1;
                        rsp.status     = ST_OK;
                        rsp.found_word = tbl_word[mid];
                        rsp.position   = POS_W'(mid);
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    // request driver, fed from the backlog
    always @(posedge i_clk) begin : drive_req
        t_req nxt_req;
        logic nxt_valid;
        nxt_req   = i_req;
        nxt_valid = i_req_valid;
        if (i_req_valid && !o_req_stall) begin
            due_rsps.push_back(table_response(i_req));
            nxt_valid = 1'b0;
        end
        if (!nxt_valid && i_rst_n && req_backlog.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
            nxt_req   = req_backlog.pop_front();
            nxt_valid = 1'b1;
        end
        i_req_valid <= nxt_valid;
        i_req       <= nxt_req;
    end

    // response stall, with an occasional long hold-off
    always @(posedge i_clk) begin : drive_rsp_stall
        if (hold_asked != hold_taken) begin
            hold_taken  <= hold_asked;
            hold_left   <= LONG_HOLD;
            i_rsp_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // response monitor
    always @(posedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (due_rsps.size() == 0) begin
                report_mismatch("unexpected response beat", o_rsp.found_word, '0);
            end else begin
                want = due_rsps.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", WORD_W'(o_rsp.status), WORD_W'(want.status));
                if (o_rsp.found_word !== want.found_word)
                    report_mismatch("found_word", o_rsp.found_word, want.found_word);
                if (o_rsp.position !== want.position)
                    report_mismatch("position", WORD_W'(o_rsp.position),
                                    WORD_W'(want.position));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic offer(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [WORD_W-1:0] word);
        t_req r;
        r.op         = op;
        r.key        = key;
        r.entry_word = word;
        req_backlog.push_back(r);
        item_total++;
    endtask

    // ascending keys with random spacing, duplicates now and then
    task automatic load_sorted(input int n);
        int k;
        int span;
        int i;
        session_keys.delete();
        span = 2 * 65535 / n;
        k    = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(65535 / (n + 1)));
        for (i = 0; i < n; i++) begin
            if (i > 0)
                k = k + int'($urandom_range(span));
            if (k > 65535)
                k = 65535;
            if (i == n - 1 && $urandom_range(3) == 0)
                k = 65535;
            session_keys.push_back(KEY_W'(k));
            offer(OP_APPEND, KEY_W'(k), {$urandom, $urandom});
        end
    endtask

    // searches: mostly hits, some neighbors, some random keys
    task automatic probe_keys(input int n);
        int i;
        int sel;
        logic [KEY_W-1:0] key;
        for (i = 0; i < n; i++) begin
            sel = $urandom_range(9);
            key = KEY_W'($urandom_range(16'hFFFF));
            if (session_keys.size() > 0 && sel < 8) begin
                key = session_keys[$urandom_range(session_keys.size() - 1)];
                if (sel == 6)
                    key = key + 1'b1;
                else if (sel == 7)
                    key = key - 1'b1;
            end
            offer(OP_SEARCH, key, {$urandom, $urandom});
        end
    endtask

    // any op, unsorted appends
    task automatic mixed_ops(input int n);
        int i;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        for (i = 0; i < n; i++) begin
            op  = OP_W'($urandom_range(3));
            key = KEY_W'($urandom_range(16'hFFFF));
            if (op == OP_CLEAR)
                session_keys.delete();
            else if (op == OP_APPEND)
                session_keys.push_back(key);
            else if (op == OP_SEARCH && session_keys.size() > 0 && $urandom_range(1))
                key = session_keys[$urandom_range(session_keys.size() - 1)];
            offer(op, key, {$urandom, $urandom});
        end
    endtask

    // sample away from the rising edge so the driver's updates have settled
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (req_backlog.size() > 0 || i_req_valid || due_rsps.size() > 0);
    endtask

    initial begin : stimulus
        int phase;
        int phase_end;
        int pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, unused op, extremes, misses, unsorted and duplicate keys
        offer(OP_SEARCH, 16'h0000, '0);
        offer(OP_UNUSED, 16'hFFFF, '1);
        offer(OP_CLEAR, 16'hFFFF, '1);
        offer(OP_APPEND, 16'h0000, '0);
        offer(OP_APPEND, 16'h0001, 64'h0123_4567_89AB_CDEF);
        offer(OP_APPEND, 16'h7FFF, 64'h8000_0000_0000_0001);
        offer(OP_APPEND, 16'hFFFF, '1);
        offer(OP_SEARCH, 16'h0000, '1);
        offer(OP_SEARCH, 16'h0001, '0);
        offer(OP_SEARCH, 16'h7FFF, '0);
        offer(OP_SEARCH, 16'hFFFF, '0);
        offer(OP_SEARCH, 16'h0002, '0);
        offer(OP_SEARCH, 16'h8000, '0);
        offer(OP_APPEND, 16'h1000, 64'hFEDC_BA98_7654_3210);
        offer(OP_SEARCH, 16'h1000, '0);
        offer(OP_APPEND, 16'h7FFF, 64'h5555_AAAA_5555_AAAA);
        offer(OP_SEARCH, 16'h7FFF, '0);
        offer(OP_UNUSED, 16'h0000, '0);
        offer(OP_CLEAR, 16'h0000, '0);
        offer(OP_SEARCH, 16'hFFFF, '0);
        offer(OP_APPEND, 16'hABCD, 64'hAAAA_5555_AAAA_5555);
        offer(OP_SEARCH, 16'hABCD, '0);
        // sender pauses until the table has answered everything
        wait_drained();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 36; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_end = item_total + PHASE_ITEMS;

            // full table, with appends past the end
            if (phase == 1) begin
                offer(OP_CLEAR, KEY_W'($urandom_range(16'hFFFF)), {$urandom, $urandom});
                load_sorted(TABLE_ENTRIES);
                offer(OP_APPEND, KEY_W'($urandom_range(16'hFFFF)), {$urandom, $urandom});
                offer(OP_APPEND, 16'hFFFF, '1);
                offer(OP_SEARCH, session_keys[TABLE_ENTRIES-1], '0);
                probe_keys(20);
            end

            // long receiver hold-off while requests keep coming
            if (phase == 2) begin
                offer(OP_CLEAR, 16'h0000, '0);
                load_sorted(12);
                probe_keys(20);
                @(posedge i_clk);
                hold_asked++;
            end

            while (item_total < phase_end) begin
                pick = $urandom_range(9);
                if (pick < 8) begin
                    offer(OP_CLEAR, KEY_W'($urandom_range(16'hFFFF)), {$urandom, $urandom});
                    load_sorted((pick == 0) ? 60 : int'($urandom_range(1, 24)));
                    probe_keys($urandom_range(4, 16));
                end else begin
                    mixed_ops(12);
                end
            end
            wait_drained();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0 && due_rsps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
